/* rtl/core/pba_pkg.sv */
// pba_pkg: sizes, command codes and shared types of the page bitmap allocator
// used by pba_seq and page_bitmap_allocator_core; depends on nothing else
package pba_pkg;

    // map geometry
    localparam int MAP_BYTES  = 131072;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int TOTAL_PAGES = MAP_BYTES * 8;
    localparam int PAGE_W     = $clog2(TOTAL_PAGES);

    // the used bits are kept as 64-bit memory words
    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int NUM_WORDS  = TOTAL_PAGES / WORD_BITS;
    localparam int WORD_AW    = $clog2(NUM_WORDS);

    // item field widths
    localparam int MODE_W     = 2;
    localparam int ADDR_W     = 32;
    localparam int RANGE_W    = 21;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_RESERVE = 2'd2,
        MODE_CLEAR   = 2'd3
    } t_mode;

    // memory access from the sequencer
    typedef struct packed {
        logic                 we;
        logic [WORD_AW-1:0]   waddr;
        logic [WORD_BITS-1:0] wdata;
        logic                 re;
        logic [WORD_AW-1:0]   raddr;
    } t_ram_req;

    // one result item
    typedef struct packed {
        logic [ADDR_W-1:0] frame_address;
        logic              out_of_pages;
    } t_result;

endpackage

/* rtl/core/pba_ram.sv */
// pba_ram: simple dual-port synchronous RAM, one write and one read port
// read data is registered; no dependencies
module pba_ram #(
    parameter int DATA_W = 64,
    parameter int ADDR_W = 14
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/pba_seq.sv */
// pba_seq: command sequencer; reads, modifies and writes back bitmap words
// depends on pba_pkg; drives the bitmap RAM through a t_ram_req struct
module pba_seq
    import pba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [ADDR_W-1:0]    i_page_address,
    input  logic [RANGE_W-1:0]   i_range_start,
    input  logic [RANGE_W-1:0]   i_range_end,
    output t_ram_req             o_ram,
    input  logic [WORD_BITS-1:0] i_rd_data,
    output logic                 o_res_valid,
    input  logic                 i_res_stall,
    output t_result              o_res
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_RSV,
        S_DONE
    } t_state;

    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);
    localparam logic [WORD_AW:0]   HINT_FULL = (WORD_AW + 1)'(NUM_WORDS);

    t_state               r_state, n_state;
    logic [WORD_AW-1:0]   r_addr, n_addr;
    logic [WORD_AW-1:0]   r_last, n_last;
    logic [BIT_W-1:0]     r_lo, n_lo;
    logic [BIT_W-1:0]     r_hi, n_hi;
    logic [WORD_AW:0]     r_hint, n_hint;
    logic                 r_cmd, n_cmd;
    t_result              r_res, n_res;

    logic [ADDR_W-1:0]    free_page;
    logic                 free_ok;
    logic                 rsv_ok;
    logic [RANGE_W-1:0]   end_m1;
    logic                 accept;
    logic                 word_full;
    logic [BIT_W-1:0]     zbit;
    logic [BIT_W-1:0]     hi_eff;
    logic [WORD_BITS-1:0] rsv_mask;
    logic [PAGE_W-1:0]    found_page;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);

    // command decode on the incoming item
    assign free_page = i_page_address >> PAGE_SHIFT;
    assign free_ok   = free_page < ADDR_W'(TOTAL_PAGES);
    assign rsv_ok    = (i_range_end > i_range_start)
                    && (ADDR_W'(i_range_end) <= ADDR_W'(TOTAL_PAGES));
    assign end_m1    = i_range_end - RANGE_W'(1);

    // lowest clear bit of the word read back
    always_comb begin
        zbit = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (!i_rd_data[k]) begin
                zbit = BIT_W'(k);
            end
        end
    end
    assign word_full  = &i_rd_data;
    assign found_page = {r_addr, zbit};

    // bits of the current word that fall inside the reserved range
    assign hi_eff   = (r_addr == r_last) ? r_hi : '1;
    assign rsv_mask = ({WORD_BITS{1'b1}} << r_lo)
                    & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_eff));

    // next state and memory requests
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_last  = r_last;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_hint  = r_hint;
        n_cmd   = r_cmd;
        n_res   = r_res;
        o_ram   = '0;

        unique case (r_state)
            S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_addr;
                o_ram.wdata = '0;
                n_hint      = '0;
                if (r_addr == LAST_WORD) begin
                    n_state = r_cmd ? S_DONE : S_IDLE;
                end else begin
                    n_addr = r_addr + WORD_AW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    unique case (t_mode'(i_mode))
                        MODE_ALLOC: begin
                            if (r_hint == HINT_FULL) begin
                                n_res.out_of_pages = 1'b1;
                                n_state            = S_DONE;
                            end else begin
                                o_ram.re    = 1'b1;
                                o_ram.raddr = r_hint[WORD_AW-1:0];
                                n_addr      = r_hint[WORD_AW-1:0];
                                n_state     = S_SCAN;
                            end
                        end
                        MODE_FREE: begin
                            if (free_ok) begin
                                o_ram.re    = 1'b1;
                                o_ram.raddr = free_page[PAGE_W-1:BIT_W];
                                n_addr      = free_page[PAGE_W-1:BIT_W];
                                n_lo        = free_page[BIT_W-1:0];
                                n_state     = S_FREE;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        MODE_RESERVE: begin
                            if (rsv_ok) begin
                                o_ram.re    = 1'b1;
                                o_ram.raddr = i_range_start[PAGE_W-1:BIT_W];
                                n_addr      = i_range_start[PAGE_W-1:BIT_W];
                                n_lo        = i_range_start[BIT_W-1:0];
                                n_last      = end_m1[PAGE_W-1:BIT_W];
                                n_hi        = end_m1[BIT_W-1:0];
                                n_state     = S_RSV;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        MODE_CLEAR: begin
                            n_addr  = '0;
                            n_cmd   = 1'b1;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // next word is fetched while the current one is checked
                o_ram.re    = 1'b1;
                o_ram.raddr = r_addr + WORD_AW'(1);
                if (!word_full) begin
                    o_ram.we            = 1'b1;
                    o_ram.waddr         = r_addr;
                    o_ram.wdata         = i_rd_data | (WORD_BITS'(1) << zbit);
                    n_res.frame_address = ADDR_W'(found_page) << PAGE_SHIFT;
                    n_hint              = {1'b0, r_addr};
                    n_state             = S_DONE;
                end else if (r_addr == LAST_WORD) begin
                    n_res.out_of_pages = 1'b1;
                    n_hint             = HINT_FULL;
                    n_state            = S_DONE;
                end else begin
                    n_addr = r_addr + WORD_AW'(1);
                end
            end
            S_FREE: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_addr;
                o_ram.wdata = i_rd_data & ~(WORD_BITS'(1) << r_lo);
                if ({1'b0, r_addr} < r_hint) begin
                    n_hint = {1'b0, r_addr};
                end
                n_state = S_DONE;
            end
            S_RSV: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_addr;
                o_ram.wdata = i_rd_data | rsv_mask;
                if (r_addr == r_last) begin
                    n_state = S_DONE;
                end else begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_addr + WORD_AW'(1);
                    n_addr      = r_addr + WORD_AW'(1);
                    n_lo        = '0;
                end
            end
            S_DONE: begin
                n_cmd = 1'b0;
                if (!i_res_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_hint  <= '0;
            r_cmd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_hint  <= n_hint;
            r_cmd   <= n_cmd;
        end
        r_last <= n_last;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_res  <= n_res;
    end

    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

/* rtl/core/page_bitmap_allocator_core.sv */
// First-fit allocator of 4 KiB page frames over a 1M-page used bitmap held in
// one RAM of 16384 words of 64 bits. One item is worked at a time. Allocate
// answers without a RAM access when the map is already known to be full;
// otherwise it scans from the lowest word that may hold a free page, one
// word a cycle. Reserve sets one 64-page word a cycle over the words the
// range touches. A range or page outside the map, or an empty range, is
// answered without a RAM access. After reset and for every clear item a
// clearing pass sweeps all 16384 words of the RAM, during which no item is
// taken. The output register lets the next item in while a result still
// waits to be taken.
//
// top level: pba_seq sequencer, pba_ram bitmap store, output register
// depends on pba_pkg, pba_seq, pba_ram
module page_bitmap_allocator_core
    import pba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [ADDR_W-1:0]  i_page_address,
    input  logic [RANGE_W-1:0] i_range_start,
    input  logic [RANGE_W-1:0] i_range_end,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [ADDR_W-1:0]  o_frame_address,
    output logic               o_out_of_pages
);

    t_ram_req             ram_req;
    logic [WORD_BITS-1:0] rd_data;
    logic                 res_valid;
    logic                 res_stall;
    logic                 res_take;
    t_result              res;

    logic                 r_o_valid;
    t_result              r_o_res;

    // sequencer
    pba_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_page_address (i_page_address),
        .i_range_start  (i_range_start),
        .i_range_end    (i_range_end),
        .o_ram          (ram_req),
        .i_rd_data      (rd_data),
        .o_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .o_res          (res)
    );

    // bitmap store
    pba_ram #(
        .DATA_W (WORD_BITS),
        .ADDR_W (WORD_AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rd_data)
    );

    // output register between the sequencer and the result channel
    assign res_stall = r_o_valid && i_stall;
    assign res_take  = res_valid && !res_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_take) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
        if (res_take) begin
            r_o_res <= res;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_frame_address = r_o_res.frame_address;
    assign o_out_of_pages  = r_o_res.out_of_pages;

endmodule

/* rtl/core/pba_checker.sv */
// pba_checker: port-level assertions for page_bitmap_allocator_core
// depends on pba_pkg; bound to the top level at the end of this file
module pba_checker
    import pba_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [ADDR_W-1:0] o_frame_address,
    input logic              o_out_of_pages
);

    // a held result item keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_address)
            && $stable(o_out_of_pages))
        else $error("result item changed while stalled");

    // a failed allocation reports address zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_pages |-> o_frame_address == '0)
        else $error("out_of_pages with non-zero address");

    // frame addresses are page aligned
    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_frame_address[PAGE_SHIFT-1:0] == '0)
        else $error("frame address not page aligned");

    // one item at a time: busy right after an item is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second item taken while busy");

    // reset starts the clearing pass with no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("not busy and empty after reset");

endmodule

bind page_bitmap_allocator_core pba_checker u_pba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_frame_address (o_frame_address),
    .o_out_of_pages  (o_out_of_pages)
);
